FILE: hdl/tpbd_pkg.sv
// tpbd_pkg: shared types, constants and pulse class functions for the tape pulse byte decoder
package tpbd_pkg;

  localparam int unsigned PULSE_W = 8;
  localparam int unsigned VER_W   = 2;
  localparam int unsigned BIT_IDX_W = 3;

  localparam logic [VER_W-1:0] VER_OVERFLOW = 2'd0;
  localparam logic [VER_W-1:0] VER_RESET    = 2'd1;

  localparam logic [1:0] EXT_BYTES = 2'd3;
  localparam logic [1:0] EXT_LOW   = 2'd3;
  localparam logic [1:0] EXT_MID   = 2'd2;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

  localparam logic [PULSE_W-1:0] SHORT_MIN  = 8'h24;
  localparam logic [PULSE_W-1:0] SHORT_MAX  = 8'h36;
  localparam logic [PULSE_W-1:0] MEDIUM_MIN = 8'h37;
  localparam logic [PULSE_W-1:0] MEDIUM_MAX = 8'h49;
  localparam logic [PULSE_W-1:0] LONG_MIN   = 8'h4a;
  localparam logic [PULSE_W-1:0] LONG_MAX   = 8'h64;

  // low 8 bits of the 0x100 overflow pulse
  localparam logic [PULSE_W-1:0] OVERFLOW_PULSE = 8'h00;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'b001,
    PH_BITS    = 3'b010,
    PH_TRAILER = 3'b100
  } phase_t;

  typedef struct packed {
    logic               valid;
    logic [PULSE_W-1:0] width;
  } pulse_t;

  function automatic logic is_short(input logic [PULSE_W-1:0] p);
    return (p >= SHORT_MIN) && (p <= SHORT_MAX);
  endfunction

  function automatic logic is_medium(input logic [PULSE_W-1:0] p);
    return (p >= MEDIUM_MIN) && (p <= MEDIUM_MAX);
  endfunction

  function automatic logic is_long(input logic [PULSE_W-1:0] p);
    return (p >= LONG_MIN) && (p <= LONG_MAX);
  endfunction

endpackage

FILE: hdl/tpbd_if.sv
// tpbd_if: valid/ready channel interfaces for tape bytes in and decoded bytes out
interface tpbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tape_byte;

  modport source (output valid, output tape_byte, input ready);
  modport sink   (input valid, input tape_byte, output ready);
endinterface

interface tpbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: hdl/tpbd_pulse_asm.sv
// tpbd_pulse_asm: builds pulse widths from raw tape bytes, including the extended zero form
module tpbd_pulse_asm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  tape_byte,
  input  logic [tpbd_pkg::VER_W-1:0]  format_version,
  output tpbd_pkg::pulse_t            pulse
);
  import tpbd_pkg::*;

  logic [1:0]         ext_left_r, ext_left_nxt;
  // only bits 10:3 of the 24-bit value survive the shift and truncation
  logic [PULSE_W-1:0] ext_acc_r, ext_acc_nxt;

  always_comb begin
    ext_left_nxt = ext_left_r;
    ext_acc_nxt  = ext_acc_r;
    pulse.valid  = 1'b0;
    pulse.width  = tape_byte;
    if (accept) begin
      if (ext_left_r != 2'd0) begin
        ext_left_nxt = ext_left_r - 2'd1;
        case (ext_left_r)
          EXT_LOW: ext_acc_nxt[4:0] = tape_byte[7:3];
          EXT_MID: ext_acc_nxt[7:5] = tape_byte[2:0];
          default: begin
            pulse.valid = 1'b1;
            pulse.width = ext_acc_r;
          end
        endcase
      end else if (tape_byte == 8'h00) begin
        if (format_version == VER_OVERFLOW) begin
          pulse.valid = 1'b1;
          pulse.width = OVERFLOW_PULSE;
        end else begin
          ext_left_nxt = EXT_BYTES;
          ext_acc_nxt  = '0;
        end
      end else begin
        pulse.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_left_r <= '0;
      ext_acc_r  <= '0;
    end else begin
      ext_left_r <= ext_left_nxt;
      ext_acc_r  <= ext_acc_nxt;
    end
  end

endmodule

FILE: hdl/tape_pulse_byte_decoder.sv
// tape_pulse_byte_decoder: top level, sync search, bit pair decode, trailer skip and output register
//
//  channel   dir  payload              transaction
//  in_ch     in   tape_byte[7:0]       valid & ready
//  out_ch    out  data_byte[7:0]       valid & ready
//  cfg       in   cfg_wdata[1:0]       cfg_we
//
//  one tape byte per cycle while in_ch.ready is high; all decode state updates at the accepting edge
//  a decoded byte is registered and shows on out_ch in the cycle after the byte that completes it
//  in_ch.ready drops only while a result is held and out_ch.ready is low
//  synchronous active-low reset, no clearing pass; format_version resets to 1
module tape_pulse_byte_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  tpbd_in_if.sink                     in_ch,
  tpbd_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [tpbd_pkg::VER_W-1:0]  cfg_wdata
);
  import tpbd_pkg::*;

  logic [VER_W-1:0]     format_version_r;
  phase_t               phase_r, phase_nxt;
  logic                 prev_valid_r, prev_valid_nxt;
  logic [PULSE_W-1:0]   prev_pulse_r, prev_pulse_nxt;
  logic [BIT_IDX_W-1:0] bit_idx_r, bit_idx_nxt;
  logic                 last_bit_r, last_bit_nxt;
  logic [7:0]           shift_r, shift_nxt;
  logic                 trail_skip_r, trail_skip_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;

  logic                 accept;
  logic                 emit;
  logic                 bit_val;
  pulse_t               pulse;

  assign in_ch.ready     = !out_valid_r || out_ch.ready;
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_byte = out_data_r;

  tpbd_pulse_asm u_pulse_asm (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .tape_byte      (in_ch.tape_byte),
    .format_version (format_version_r),
    .pulse          (pulse)
  );

  always_comb begin
    phase_nxt      = phase_r;
    prev_valid_nxt = prev_valid_r;
    prev_pulse_nxt = prev_pulse_r;
    bit_idx_nxt    = bit_idx_r;
    last_bit_nxt   = last_bit_r;
    shift_nxt      = shift_r;
    trail_skip_nxt = trail_skip_r;
    emit           = 1'b0;
    bit_val        = last_bit_r;
    if (is_short(prev_pulse_r) && (is_medium(pulse.width) || is_long(pulse.width))) begin
      bit_val = 1'b0;
    end
    if ((is_medium(prev_pulse_r) || is_long(prev_pulse_r)) && is_short(pulse.width)) begin
      bit_val = 1'b1;
    end
    if (pulse.valid) begin
      unique case (phase_r)
        PH_SYNC: begin
          if (prev_valid_r && is_long(prev_pulse_r) && is_medium(pulse.width)) begin
            phase_nxt      = PH_BITS;
            prev_valid_nxt = 1'b0;
            bit_idx_nxt    = '0;
            last_bit_nxt   = 1'b0;
            shift_nxt      = '0;
          end else begin
            prev_pulse_nxt = pulse.width;
            prev_valid_nxt = 1'b1;
          end
        end
        PH_BITS: begin
          if (!prev_valid_r) begin
            prev_pulse_nxt = pulse.width;
            prev_valid_nxt = 1'b1;
          end else begin
            prev_valid_nxt = 1'b0;
            last_bit_nxt   = bit_val;
            shift_nxt      = {bit_val, shift_r[7:1]};
            if (bit_idx_r == LAST_BIT_IDX) begin
              bit_idx_nxt    = '0;
              phase_nxt      = PH_TRAILER;
              trail_skip_nxt = 1'b1;
            end else begin
              bit_idx_nxt = bit_idx_r + 3'd1;
            end
          end
        end
        PH_TRAILER: begin
          if (trail_skip_r) begin
            trail_skip_nxt = 1'b0;
          end else begin
            phase_nxt      = PH_SYNC;
            prev_valid_nxt = 1'b0;
            emit           = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_SYNC;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = shift_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_version_r <= VER_RESET;
      phase_r          <= PH_SYNC;
      prev_valid_r     <= 1'b0;
      prev_pulse_r     <= '0;
      bit_idx_r        <= '0;
      last_bit_r       <= 1'b0;
      shift_r          <= '0;
      trail_skip_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        format_version_r <= cfg_wdata;
      end
      phase_r      <= phase_nxt;
      prev_valid_r <= prev_valid_nxt;
      prev_pulse_r <= prev_pulse_nxt;
      bit_idx_r    <= bit_idx_nxt;
      last_bit_r   <= last_bit_nxt;
      shift_r      <= shift_nxt;
      trail_skip_r <= trail_skip_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
